/* rtl/mur2_pkg.sv */
`timescale 1ns / 1ps

package mur2_pkg;

    // Hash constants.
    localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
    localparam int unsigned MIX_SHIFT   = 24;
    localparam int unsigned FIN_SHIFT_A = 13;
    localparam int unsigned FIN_SHIFT_B = 15;
    localparam logic [31:0] SEED_RESET  = 32'h01000193;

    // A word with this many bytes is a full word; larger counts saturate to it.
    localparam logic [2:0] FULL_BYTES = 3'd4;

    // Work queue between the front and back ends.
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Kind of work that one key word brings to the back end.
    typedef enum logic [1:0] {
        OP_EMPTY,
        OP_TAIL,
        OP_FULL
    } t_op;

    // One classified word, ready for the hash recurrence.
    typedef struct packed {
        t_op         op;
        logic        first;
        logic        emit;
        logic [31:0] data;
        logic [31:0] start;
    } t_work;

    // Back end sequencer states.
    typedef enum logic [1:0] {
        BK_RUN,
        BK_FIN1,
        BK_FIN2
    } t_back_state;

    // Product modulo 2^32.
    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] prod;
        prod = a * b;
        return prod[31:0];
    endfunction

endpackage

/* rtl/murmur2_hash32_core.sv */
`timescale 1ns / 1ps

// 32-bit MurmurHash2 of a key streamed as little-endian words. A front end
// classifies each word and runs the two key multiplies in a two-stage pipeline;
// a two-entry queue feeds a back end that owns the running hash and its
// multiplies. A word that ends a key (last mark, or fewer than four bytes) goes
// through the hash update, then the finalization multiply and then the load of
// the output register, which waits while a result is still held; the back end
// takes no new word until that load. The hash multiply recurrence sets the rate.
// The seed register may be written only while idle.
module murmur2_hash32_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [31:0]  i_cfg_hash_seed,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [31:0]  i_key_word,
    input  logic [2:0]   i_byte_count,
    input  logic         i_first_word,
    input  logic         i_last_word,
    input  logic [30:0]  i_key_length,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [31:0]  o_hash_value
);
    import mur2_pkg::*;

    logic  push;
    t_work push_data;
    logic  queue_full;
    logic  pop;
    logic  pop_valid;
    t_work pop_data;

    // Front end: seed register, classification, key mixing.
    mur2_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_hash_seed (i_cfg_hash_seed),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_key_word      (i_key_word),
        .i_byte_count    (i_byte_count),
        .i_first_word    (i_first_word),
        .i_last_word     (i_last_word),
        .i_key_length    (i_key_length),
        .o_push          (push),
        .o_push_data     (push_data),
        .i_queue_full    (queue_full)
    );

    // Work queue decoupling the two ends.
    mur2_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (queue_full),
        .o_pop_valid (pop_valid),
        .o_pop_data  (pop_data),
        .i_pop       (pop)
    );

    // Back end: hash recurrence, finalization, result register.
    mur2_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work_valid (pop_valid),
        .i_work       (pop_data),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_hash_value (o_hash_value)
    );

endmodule

/* rtl/mur2_front.sv */
`timescale 1ns / 1ps

module mur2_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [31:0]          i_cfg_hash_seed,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [31:0]          i_key_word,
    input  logic [2:0]           i_byte_count,
    input  logic                 i_first_word,
    input  logic                 i_last_word,
    input  logic [30:0]          i_key_length,
    output logic                 o_push,
    output mur2_pkg::t_work      o_push_data,
    input  logic                 i_queue_full
);
    import mur2_pkg::*;

    logic [31:0] r_seed;
    logic        r_s1_valid;
    t_work       r_s1;
    t_work       n_s1;
    logic        r_s2_valid;
    t_work       r_s2;
    t_work       n_s2;
    logic [2:0]  cnt_sat;
    logic [31:0] s1_mixed;
    logic        s2_free;
    logic        s1_move;
    logic        in_beat;

    // Seed register; writes must land only while the block is idle, which the block itself does not enforce.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= SEED_RESET;
        end else if (i_cfg_valid) begin
            r_seed <= i_cfg_hash_seed;
        end
    end

    // Pipeline flow control: stage two drains into the queue.
    assign s2_free = !r_s2_valid || !i_queue_full;
    assign s1_move = r_s1_valid && s2_free;
    assign o_ready = !r_s1_valid || s2_free;
    assign in_beat = i_valid && o_ready;
    assign o_push  = r_s2_valid && !i_queue_full;
    assign o_push_data = r_s2;

    // Stage one: classify the word, mask a tail, first multiply of a full word.
    always_comb begin
        cnt_sat     = (i_byte_count > FULL_BYTES) ? FULL_BYTES : i_byte_count;
        n_s1.first  = i_first_word;
        n_s1.emit   = i_last_word || (cnt_sat != FULL_BYTES);
        n_s1.start  = r_seed ^ {1'b0, i_key_length};
        case (cnt_sat)
            3'd0: begin
                n_s1.op   = OP_EMPTY;
                n_s1.data = '0;
            end
            3'd1: begin
                n_s1.op   = OP_TAIL;
                n_s1.data = {24'b0, i_key_word[7:0]};
            end
            3'd2: begin
                n_s1.op   = OP_TAIL;
                n_s1.data = {16'b0, i_key_word[15:0]};
            end
            3'd3: begin
                n_s1.op   = OP_TAIL;
                n_s1.data = {8'b0, i_key_word[23:0]};
            end
            default: begin
                n_s1.op   = OP_FULL;
                n_s1.data = mul32(i_key_word, MIX_MUL);
            end
        endcase
    end

    // Stage two: xor-shift and second multiply of a full word.
    always_comb begin
        s1_mixed = r_s1.data ^ (r_s1.data >> MIX_SHIFT);
        n_s2     = r_s1;
        if (r_s1.op == OP_FULL) begin
            n_s2.data = mul32(s1_mixed, MIX_MUL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_s1 <= n_s1;
        end
        if (s1_move) begin
            r_s2 <= n_s2;
        end
    end

endmodule

/* rtl/mur2_queue.sv */
`timescale 1ns / 1ps

module mur2_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  mur2_pkg::t_work      i_push_data,
    output logic                 o_full,
    output logic                 o_pop_valid,
    output mur2_pkg::t_work      o_pop_data,
    input  logic                 i_pop
);
    import mur2_pkg::*;

    t_work                r_entry [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  r_wr_ptr;
    logic [QUEUE_AW-1:0]  r_rd_ptr;
    logic [QUEUE_CW-1:0]  r_count;
    logic                 do_push;
    logic                 do_pop;

    assign o_full      = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_pop_valid = (r_count != '0);
    assign o_pop_data  = r_entry[r_rd_ptr];
    assign do_push     = i_push && !o_full;
    assign do_pop      = i_pop && o_pop_valid;

    // Pointer wrap at the queue depth.
    function automatic logic [QUEUE_AW-1:0] next_ptr(input logic [QUEUE_AW-1:0] p);
        return (p == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

/* rtl/mur2_back.sv */
`timescale 1ns / 1ps

module mur2_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_work_valid,
    input  mur2_pkg::t_work      i_work,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [31:0]          o_hash_value
);
    import mur2_pkg::*;

    t_back_state r_state;
    t_back_state n_state;
    logic [31:0] r_hash;
    logic [31:0] n_hash;
    logic [31:0] r_fin;
    logic [31:0] n_fin;
    logic        r_out_valid;
    logic        n_out_valid;
    logic [31:0] r_out;
    logic [31:0] n_out;
    logic [31:0] h_in;

    assign o_valid      = r_out_valid;
    assign o_hash_value = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_RUN;
            r_hash      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hash      <= n_hash;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fin <= n_fin;
        r_out <= n_out;
    end

    // Hash recurrence, then a two-step finalization into the output register.
    always_comb begin
        n_state     = r_state;
        n_hash      = r_hash;
        n_fin       = r_fin;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        o_pop       = 1'b0;
        h_in        = i_work.first ? i_work.start : r_hash;
        case (r_state)
            BK_RUN: begin
                if (i_work_valid) begin
                    o_pop = 1'b1;
                    case (i_work.op)
                        OP_FULL:  n_hash = mul32(h_in, MIX_MUL) ^ i_work.data;
                        OP_TAIL:  n_hash = mul32(h_in ^ i_work.data, MIX_MUL);
                        default:  n_hash = h_in;
                    endcase
                    if (i_work.emit) begin
                        n_state = BK_FIN1;
                    end
                end
            end
            BK_FIN1: begin
                n_fin   = mul32(r_hash ^ (r_hash >> FIN_SHIFT_A), MIX_MUL);
                n_state = BK_FIN2;
            end
            BK_FIN2: begin
                if (!r_out_valid || i_ready) begin
                    n_out       = r_fin ^ (r_fin >> FIN_SHIFT_B);
                    n_out_valid = 1'b1;
                    n_state     = BK_RUN;
                end
            end
            default: begin
                n_state = BK_RUN;
            end
        endcase
    end

    // Finalization always runs its multiply step straight into the output step.
    a_fin_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_FIN1 |=> r_state == BK_FIN2)
        else $error("finalize multiply not followed by output step");

    // The queue is drained only while the recurrence is running.
    a_pop_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> r_state == BK_RUN)
        else $error("queue popped during finalization");

    // A held result blocks the next one from being loaded.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_FIN2 && r_out_valid && !i_ready) |=> r_state == BK_FIN2)
        else $error("result overwritten while still held");

    // The hash state does not move while a key is being finalized.
    a_hash_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != BK_RUN) |=> $stable(r_hash))
        else $error("running hash changed during finalization");

endmodule

/* tb/murmur2_hash_checker.sv */
`timescale 1ns / 1ps

// Watches the configuration, key and hash channels of the hash core. It keeps
// its own copy of the seed and the running hash, works out the finalized hash
// for every key word that ends a key, and compares each hash beat against the
// oldest outstanding prediction.
module murmur2_hash_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic [31:0] i_cfg_hash_seed,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic [31:0] i_key_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_first_word,
    input  logic        i_last_word,
    input  logic [30:0] i_key_length,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [31:0] o_hash_value,
    output int          o_fail_count,
    output int          o_pending
);
    import mur2_pkg::*;

    // Shadow copies of the seed register and the unfinalized hash.
    logic [31:0] seed_shadow;
    logic [31:0] running_hash;
    logic [31:0] word_hash;
    logic [31:0] pending_hashes[$];
    int          fail_count = 0;

    // Fold one key word into the running hash. Counts above a full word
    // saturate, and bytes beyond the count are masked off.
    function automatic logic [31:0] absorb_word(input logic [31:0] h,
                                                input logic [31:0] word,
                                                input logic [2:0]  count);
        t_op         op;
        logic [2:0]  nbytes;
        logic [31:0] k;
        logic [31:0] mask;
        nbytes = (count > FULL_BYTES) ? FULL_BYTES : count;
        if (nbytes == FULL_BYTES) begin
            op = OP_FULL;
        end else if (nbytes == 3'd0) begin
            op = OP_EMPTY;
        end else begin
            op = OP_TAIL;
        end
        case (op)
            OP_FULL: begin
                k = word * MIX_MUL;
                k = k ^ (k >> MIX_SHIFT);
                k = k * MIX_MUL;
                h = (h * MIX_MUL) ^ k;
            end
            OP_TAIL: begin
                mask = (32'd1 << (8 * nbytes)) - 32'd1;
                h = (h ^ (word & mask)) * MIX_MUL;
            end
            default: begin
            end
        endcase
        return h;
    endfunction

    // Final avalanche applied when a key ends.
    function automatic logic [31:0] finalize_hash(input logic [31:0] h);
        logic [31:0] f;
        f = h ^ (h >> FIN_SHIFT_A);
        f = f * MIX_MUL;
        f = f ^ (f >> FIN_SHIFT_B);
        return f;
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t ns: %s: expected %08h, got %08h", $time, what, want, got);
        end
    endtask

    // All three channels are sampled at the rising edge. A hash beat always
    // belongs to an older key word, so it is checked before the new word is
    // folded in.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seed_shadow  = SEED_RESET;
            running_hash = '0;
            pending_hashes.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                seed_shadow = i_cfg_hash_seed;
            end
            if (o_valid && i_ready) begin
                if (pending_hashes.size() == 0) begin
                    note_mismatch("hash beat with none outstanding", '0, o_hash_value);
                end else if (o_hash_value !== pending_hashes[0]) begin
                    note_mismatch("hash_value", pending_hashes[0], o_hash_value);
                    void'(pending_hashes.pop_front());
                end else begin
                    void'(pending_hashes.pop_front());
                end
            end
            if (i_valid && o_ready) begin
                word_hash = i_first_word ? (seed_shadow ^ {1'b0, i_key_length})
                                         : running_hash;
                word_hash    = absorb_word(word_hash, i_key_word, i_byte_count);
                running_hash = word_hash;
                // A short word ends the key even without the last mark.
                if (i_last_word || (i_byte_count < FULL_BYTES)) begin
                    pending_hashes.push_back(finalize_hash(word_hash));
                end
            end
        end
        o_pending    = pending_hashes.size();
        o_fail_count = fail_count;
    end

endmodule

/* tb/murmur2_hash32_core_tb.sv */
`timescale 1ns / 1ps

module murmur2_hash32_core_tb;
    import mur2_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_WORDS  = 85;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_hash_seed;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_key_word;
    logic [2:0]  i_byte_count;
    logic        i_first_word;
    logic        i_last_word;
    logic [30:0] i_key_length;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_hash_value;
    int          o_fail_count;
    int          o_pending;

    int          words_sent = 0;
    bit          burst_mode = 1'b0;

    murmur2_hash32_core dut (.*);

    murmur2_hash_checker u_checker (.*);

    // 4 ns clock.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Hard stop in case the core hangs.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("CHECKS FAILED");
        $finish;
    end

    // Hash sink: stalls a random number of cycles before each beat, except
    // during bursts where it stays ready.
    initial begin
        int stall;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = burst_mode ? 0 : $urandom_range(0, 14);
            repeat (stall) begin
                i_ready <= 1'b0;
                @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
            @(negedge i_clk);
        end
    end

    // Drive one key word beat. Valid is left high so that a back-to-back
    // beat does not drop it between the two beats.
    task automatic send_word(input logic [31:0] word, input logic [2:0] count,
                             input logic first, input logic last,
                             input logic [30:0] key_len);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_key_word   <= word;
        i_byte_count <= count;
        i_first_word <= first;
        i_last_word  <= last;
        i_key_length <= key_len;
        do @(posedge i_clk); while (!(i_valid && o_ready));
        @(negedge i_clk);
        words_sent++;
    endtask

    // Let every outstanding hash arrive, then give the core time to retire
    // any word that produces no hash.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (o_pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_seed(input logic [31:0] seed);
        i_cfg_valid     <= 1'b1;
        i_cfg_hash_seed <= seed;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // One well-formed key with random bytes. Most keys are short; the length
    // field is occasionally unrelated to the bytes actually sent.
    task automatic send_key();
        int          key_bytes;
        int          full_words;
        int          tail_bytes;
        int          pick;
        logic [30:0] len_field;
        logic [2:0]  count;
        burst_mode = ($urandom_range(0, 4) == 0);
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            key_bytes = $urandom_range(0, 16);
        end else if (pick < 9) begin
            key_bytes = $urandom_range(17, 48);
        end else begin
            key_bytes = $urandom_range(49, 128);
        end
        full_words = key_bytes / 4;
        tail_bytes = key_bytes % 4;
        len_field  = ($urandom_range(0, 7) == 0) ? 31'($urandom) : 31'(key_bytes);
        if (key_bytes == 0) begin
            send_word($urandom, 3'd0, 1'b1, 1'($urandom_range(0, 1)), len_field);
        end else begin
            for (int i = 0; i < full_words; i++) begin
                count = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7)) : FULL_BYTES;
                send_word($urandom, count, (i == 0),
                          (tail_bytes == 0) && (i == full_words - 1), len_field);
            end
            if (tail_bytes != 0) begin
                send_word($urandom, 3'(tail_bytes), (full_words == 0),
                          ($urandom_range(0, 3) != 0), len_field);
            end
        end
    endtask

    // Mostly whole keys, with some arbitrary words mixed in. The phase always
    // closes on a whole key so that the core ends up idle.
    task automatic random_keys(input int n_words);
        int target;
        target = words_sent + n_words;
        while (words_sent < target) begin
            if ($urandom_range(0, 9) == 0) begin
                burst_mode = ($urandom_range(0, 4) == 0);
                send_word($urandom, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 31'($urandom));
            end else begin
                send_key();
            end
        end
        send_key();
    endtask

    initial begin
        logic [31:0] seed_plan [4];
        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_hash_seed = '0;
        i_valid         = 1'b0;
        i_key_word      = '0;
        i_byte_count    = '0;
        i_first_word    = 1'b0;
        i_last_word     = 1'b0;
        i_key_length    = '0;
        seed_plan[0] = 32'h0000_0000;
        seed_plan[1] = 32'hffff_ffff;
        seed_plan[2] = $urandom;
        seed_plan[3] = $urandom;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Words without a start right after reset continue from a zero hash;
        // the short one ends the key without a last mark.
        send_word(32'hffff_ffff, FULL_BYTES, 1'b0, 1'b0, 31'd0);
        send_word(32'h1234_5678, 3'd2, 1'b0, 1'b0, 31'd0);
        // Empty key, then single short keys with junk above the valid bytes.
        send_word(32'hffff_ffff, 3'd0, 1'b1, 1'b1, 31'd0);
        send_word(32'hffff_ffff, 3'd1, 1'b1, 1'b1, 31'd1);
        send_word(32'ha5a5_a5a5, 3'd2, 1'b1, 1'b1, 31'd2);
        send_word(32'hffff_ffff, 3'd3, 1'b1, 1'b1, 31'd3);
        // Single full words at the extremes of the word and the length.
        send_word(32'h0000_0000, FULL_BYTES, 1'b1, 1'b1, 31'd4);
        send_word(32'hffff_ffff, FULL_BYTES, 1'b1, 1'b1, 31'h7fff_ffff);
        // Counts above four saturate to a full word.
        send_word(32'h0f1e_2d3c, 3'd5, 1'b1, 1'b1, 31'd4);
        send_word(32'hcafe_f00d, 3'd6, 1'b1, 1'b0, 31'd8);
        send_word(32'h8765_4321, 3'd7, 1'b0, 1'b1, 31'd8);
        // A word without a start right after a key has ended.
        send_word(32'hdead_beef, FULL_BYTES, 1'b0, 1'b1, 31'd0);
        // Three-word key closed by an unmarked short tail.
        send_word(32'h0403_0201, FULL_BYTES, 1'b1, 1'b0, 31'd11);
        send_word(32'h0807_0605, FULL_BYTES, 1'b0, 1'b0, 31'd11);
        send_word(32'hff0b_0a09, 3'd3, 1'b0, 1'b0, 31'd11);
        // A new start in the middle of a key, with lengths that do not match.
        send_word(32'h1111_1111, FULL_BYTES, 1'b1, 1'b0, 31'd100);
        send_word(32'h2222_2222, FULL_BYTES, 1'b1, 1'b0, 31'd5);
        send_word(32'h3333_3333, 3'd1, 1'b0, 1'b1, 31'd5);
        // Empty words without a last mark, the first also without a start.
        send_word(32'h5555_5555, 3'd0, 1'b0, 1'b0, 31'd0);
        send_word(32'haaaa_aaaa, 3'd0, 1'b1, 1'b0, 31'h4000_0000);
        send_word(32'h8000_0000, FULL_BYTES, 1'b1, 1'b1, 31'h2aaa_aaaa);
        send_word(32'h0000_0001, FULL_BYTES, 1'b1, 1'b1, 31'h5555_5555);

        // Random keys under the reset seed, then under each planned seed.
        random_keys(PHASE_WORDS);
        for (int p = 0; p < 4; p++) begin
            wait_idle();
            write_seed(seed_plan[p]);
            random_keys(PHASE_WORDS);
        end

        wait_idle();
        if (o_fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
